// ===== design/htw_pkg.sv =====
// ---------------------------------------------------------------------------
// htw_pkg: shared types and constants of the hashed timer wheel
// Sizes of the wheel and timer pool, command codes and the queued word.
// ---------------------------------------------------------------------------
package htw_pkg;

  localparam int WHEEL_SLOTS = 64;
  localparam int TIMER_POOL  = 64;
  localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
  localparam int ID_W        = $clog2(TIMER_POOL);
  localparam int LINK_W      = ID_W + 1;
  localparam int TURNS_W     = 14;
  localparam int TMO_W       = 21;
  localparam int DVD_W       = TMO_W - 1;
  localparam int DVS_W       = 8;
  localparam int FIFO_DEPTH  = 2;
  localparam int FPTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [LINK_W-1:0]  NO_LINK   = LINK_W'(TIMER_POOL);
  localparam logic [TURNS_W-1:0] TURNS_MAX = '1;

  // input kind codes
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_ADJUST = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // classified command codes
  localparam logic [1:0] CMD_NOP  = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [ID_W-1:0]  id;
    logic             neg;
    logic [DVD_W-1:0] tmo;
  } cmd_t;

endpackage

// ===== design/hashed_timer_wheel.sv =====
// With the queue empty and the sequencer idle, a tick holds each expired timer back
// until the next one expires, so its first word leaves once the second expired timer
// is found; if fewer than two expire, it leaves last, at the end of the walk,
// as a none word if none expire. A tick walks its slot list one listed timer per cycle.
// Add and adjust with a non-negative timeout wait for the bit-serial tick count divider.
// A two-word queue lets commands arrive while one executes.
// Results leave at most one per cycle on a strobe; the receiver cannot stall.
// Reset: synchronous, active low; empties the wheel, tick interval returns to 1.
// ---------------------------------------------------------------------------
// hashed_timer_wheel: hashed timing wheel top level
// Intake stage, command queue and execution sequencer over a pool of timers.
// ---------------------------------------------------------------------------
module hashed_timer_wheel (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_kind,
  input  logic [htw_pkg::ID_W-1:0]         in_timer_id,
  input  logic signed [htw_pkg::TMO_W-1:0] in_timeout,
  input  logic                             cfg_we,
  input  logic [htw_pkg::DVS_W-1:0]        cfg_data,
  output logic                             out_strobe,
  output logic [htw_pkg::ID_W-1:0]         out_expired_id,
  output logic                             out_expired,
  output logic                             out_last
);

  logic          q_full, q_push, q_pop, q_empty;
  htw_pkg::cmd_t push_cmd, head_cmd;

  htw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_timer_id (in_timer_id),
    .in_timeout  (in_timeout),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  htw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  htw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .q_empty        (q_empty),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .out_strobe     (out_strobe),
    .out_expired_id (out_expired_id),
    .out_expired    (out_expired),
    .out_last       (out_last)
  );

endmodule

// ===== design/htw_front.sv =====
// ---------------------------------------------------------------------------
// htw_front: command intake
// Accepts a word, classifies it into a queued command and hands it on.
// ---------------------------------------------------------------------------
module htw_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic [htw_pkg::ID_W-1:0] in_timer_id,
  input  logic signed [htw_pkg::TMO_W-1:0] in_timeout,
  input  logic                    q_full,
  output logic                    q_push,
  output htw_pkg::cmd_t           q_cmd
);

  logic          vld_r, vld_nxt;
  htw_pkg::cmd_t cmd_r, cmd_nxt;
  logic          accept;

  assign busy   = vld_r & q_full;
  assign accept = start & ~busy;
  assign q_push = vld_r & ~q_full;
  assign q_cmd  = cmd_r;

  // classify the incoming word
  always_comb begin
    cmd_nxt     = cmd_r;
    cmd_nxt.id  = in_timer_id;
    cmd_nxt.neg = in_timeout[htw_pkg::TMO_W-1];
    cmd_nxt.tmo = in_timeout[htw_pkg::DVD_W-1:0];
    case (in_kind)
      htw_pkg::KIND_ADD, htw_pkg::KIND_ADJUST: cmd_nxt.op = htw_pkg::CMD_SET;
      htw_pkg::KIND_DELETE:                     cmd_nxt.op = htw_pkg::CMD_DEL;
      htw_pkg::KIND_TICK:                       cmd_nxt.op = htw_pkg::CMD_TICK;
      default:                                  cmd_nxt.op = htw_pkg::CMD_NOP;
    endcase
    vld_nxt = accept | (vld_r & ~q_push);
  end

  // hold the classified word until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== design/htw_fifo.sv =====
// ---------------------------------------------------------------------------
// htw_fifo: command queue
// Short queue that decouples the intake from the execution sequencer.
// ---------------------------------------------------------------------------
module htw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output htw_pkg::cmd_t head_cmd
);

  htw_pkg::cmd_t                   ent_r [htw_pkg::FIFO_DEPTH];
  logic [htw_pkg::FPTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [htw_pkg::FCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full     = (cnt_r == htw_pkg::FCNT_W'(htw_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = ent_r[rp_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  // advance pointers
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== design/htw_div.sv =====
// ---------------------------------------------------------------------------
// htw_div: tick count divider
// Restoring divider, one quotient bit per cycle, timeout by tick interval.
// ---------------------------------------------------------------------------
module htw_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [htw_pkg::DVD_W-1:0]  dividend,
  input  logic [htw_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [htw_pkg::DVD_W-1:0]  quot
);

  localparam int CNT_W = $clog2(htw_pkg::DVD_W + 1);

  logic [htw_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [htw_pkg::DVS_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [htw_pkg::DVS_W:0]   trial;

  assign done = done_r;
  assign quot = q_r;
  assign trial = {rem_r, q_r[htw_pkg::DVD_W-1]};

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(htw_pkg::DVD_W);
      done_nxt = 1'b0;
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = htw_pkg::DVS_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[htw_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[htw_pkg::DVS_W-1:0];
        q_nxt   = {q_r[htw_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

endmodule

// ===== design/htw_back.sv =====
// ---------------------------------------------------------------------------
// htw_back: wheel execution sequencer
// Owns the slot heads and timer link memories; runs insert, unlink and the
// slot walk of a tick, and reports expired timers.
// ---------------------------------------------------------------------------
module htw_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [htw_pkg::DVS_W-1:0] cfg_data,
  input  logic                      q_empty,
  input  htw_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      out_strobe,
  output logic [htw_pkg::ID_W-1:0]  out_expired_id,
  output logic                      out_expired,
  output logic                      out_last
);

  localparam int ID_W   = htw_pkg::ID_W;
  localparam int SLOT_W = htw_pkg::SLOT_W;
  localparam int LINK_W = htw_pkg::LINK_W;
  localparam int TRN_W  = htw_pkg::TURNS_W;
  localparam int DVD_W  = htw_pkg::DVD_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TK_HD  = 3'd1;
  localparam logic [2:0] S_TK_WLK = 3'd2;
  localparam logic [2:0] S_TK_END = 3'd3;
  localparam logic [2:0] S_UL     = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_INS    = 3'd6;
  localparam logic [2:0] S_INS2   = 3'd7;

  // memories
  logic [LINK_W-1:0] hd_mem [htw_pkg::WHEEL_SLOTS];
  logic [LINK_W-1:0] nx_mem [htw_pkg::TIMER_POOL];
  logic [LINK_W-1:0] pv_mem [htw_pkg::TIMER_POOL];
  logic [SLOT_W-1:0] sl_mem [htw_pkg::TIMER_POOL];
  logic [TRN_W-1:0]  tn_mem [htw_pkg::TIMER_POOL];

  logic [htw_pkg::WHEEL_SLOTS-1:0] hd_vld_r;
  logic [htw_pkg::TIMER_POOL-1:0]  act_r;

  logic [LINK_W-1:0] hd_q, nx_q, pv_q;
  logic [SLOT_W-1:0] sl_q;
  logic [TRN_W-1:0]  tn_q;
  logic              hd_vq;
  logic [LINK_W-1:0] head_out;

  // memory controls
  logic [SLOT_W-1:0] hd_raddr, hd_waddr;
  logic [ID_W-1:0]   rc_raddr, nx_waddr, pv_waddr, tn_waddr, sl_waddr;
  logic              hd_we, nx_we, pv_we, tn_we, sl_we;
  logic [LINK_W-1:0] hd_wdata, nx_wdata, pv_wdata;
  logic [TRN_W-1:0]  tn_wdata;
  logic [SLOT_W-1:0] sl_wdata;
  logic              act_set, act_clr;
  logic [ID_W-1:0]   act_addr;

  // sequencer state
  logic [2:0]          state_r, state_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt, tslot_r, tslot_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [LINK_W-1:0]   t_r, t_nxt, kept_r, kept_nxt, h_r, h_nxt;
  logic                ins_r, ins_nxt;
  logic                pend_r, pend_nxt;
  logic [ID_W-1:0]     pid_r, pid_nxt;
  logic [TRN_W-1:0]    turns_r, turns_nxt;
  logic [htw_pkg::DVS_W-1:0] ti_r;

  logic                ostb_nxt, oexp_nxt, olast_nxt;
  logic [ID_W-1:0]     oid_nxt;
  logic                ostb_r, oexp_r, olast_r;
  logic [ID_W-1:0]     oid_r;

  // divider
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_q, ticks;
  logic [htw_pkg::DVS_W-1:0] dvs;
  logic [DVD_W-SLOT_W-1:0]   turns_full;

  assign dvs = (ti_r == '0) ? htw_pkg::DVS_W'(1) : ti_r;

  htw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_cmd.tmo),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  assign ticks      = (div_q == '0) ? DVD_W'(1) : div_q;
  assign turns_full = ticks[DVD_W-1:SLOT_W];
  assign head_out   = hd_vq ? hd_q : htw_pkg::NO_LINK;

  assign out_strobe     = ostb_r;
  assign out_expired_id = oid_r;
  assign out_expired    = oexp_r;
  assign out_last       = olast_r;

  // sequence one command
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    tslot_nxt = tslot_r;
    id_nxt    = id_r;
    t_nxt     = t_r;
    kept_nxt  = kept_r;
    h_nxt     = h_r;
    ins_nxt   = ins_r;
    pend_nxt  = pend_r;
    pid_nxt   = pid_r;
    turns_nxt = turns_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    hd_raddr  = cur_r;
    rc_raddr  = t_r[ID_W-1:0];
    hd_we = 1'b0; hd_waddr = cur_r;        hd_wdata = nx_q;
    nx_we = 1'b0; nx_waddr = id_r;         nx_wdata = nx_q;
    pv_we = 1'b0; pv_waddr = id_r;         pv_wdata = pv_q;
    tn_we = 1'b0; tn_waddr = id_r;         tn_wdata = turns_r;
    sl_we = 1'b0; sl_waddr = id_r;         sl_wdata = tslot_r;
    act_set = 1'b0; act_clr = 1'b0;        act_addr = id_r;
    ostb_nxt = 1'b0; oid_nxt = pid_r; oexp_nxt = 1'b1; olast_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          id_nxt = q_cmd.id;
          case (q_cmd.op)
            htw_pkg::CMD_TICK: begin
              hd_raddr  = cur_r;
              kept_nxt  = htw_pkg::NO_LINK;
              pend_nxt  = 1'b0;
              state_nxt = S_TK_HD;
            end
            htw_pkg::CMD_DEL: begin
              if (act_r[q_cmd.id]) begin
                rc_raddr  = q_cmd.id;
                ins_nxt   = 1'b0;
                state_nxt = S_UL;
              end
            end
            htw_pkg::CMD_SET: begin
              div_start = ~q_cmd.neg;
              ins_nxt   = ~q_cmd.neg;
              if (act_r[q_cmd.id]) begin
                rc_raddr  = q_cmd.id;
                state_nxt = S_UL;
              end else if (!q_cmd.neg) begin
                state_nxt = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_TK_HD: begin
        if (head_out == htw_pkg::NO_LINK) begin
          state_nxt = S_TK_END;
        end else begin
          rc_raddr  = head_out[ID_W-1:0];
          t_nxt     = head_out;
          state_nxt = S_TK_WLK;
        end
      end
      S_TK_WLK: begin
        // visit one timer of the current slot
        if (tn_q != '0) begin
          tn_we    = 1'b1;
          tn_waddr = t_r[ID_W-1:0];
          tn_wdata = tn_q - 1'b1;
          kept_nxt = t_r;
        end else begin
          if (kept_r == htw_pkg::NO_LINK) begin
            hd_we    = 1'b1;
            hd_waddr = cur_r;
            hd_wdata = nx_q;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = kept_r[ID_W-1:0];
            nx_wdata = nx_q;
          end
          if (nx_q != htw_pkg::NO_LINK) begin
            pv_we    = 1'b1;
            pv_waddr = nx_q[ID_W-1:0];
            pv_wdata = kept_r;
          end
          act_clr  = 1'b1;
          act_addr = t_r[ID_W-1:0];
          ostb_nxt = pend_r;
          pend_nxt = 1'b1;
          pid_nxt  = t_r[ID_W-1:0];
        end
        if (nx_q == htw_pkg::NO_LINK) begin
          state_nxt = S_TK_END;
        end else begin
          rc_raddr = nx_q[ID_W-1:0];
          t_nxt    = nx_q;
        end
      end
      S_TK_END: begin
        // flush the held result as the last one, or report none
        ostb_nxt  = 1'b1;
        olast_nxt = 1'b1;
        oexp_nxt  = pend_r;
        oid_nxt   = pend_r ? pid_r : '0;
        pend_nxt  = 1'b0;
        cur_nxt   = cur_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_UL: begin
        // unlink the timer from its slot list
        if (pv_q == htw_pkg::NO_LINK) begin
          hd_we    = 1'b1;
          hd_waddr = sl_q;
          hd_wdata = nx_q;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = pv_q[ID_W-1:0];
          nx_wdata = nx_q;
        end
        if (nx_q != htw_pkg::NO_LINK) begin
          pv_we    = 1'b1;
          pv_waddr = nx_q[ID_W-1:0];
          pv_wdata = pv_q;
        end
        act_clr   = 1'b1;
        state_nxt = ins_r ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          tslot_nxt = cur_r + ticks[SLOT_W-1:0];
          hd_raddr  = tslot_nxt;
          turns_nxt = (turns_full > (DVD_W-SLOT_W)'(htw_pkg::TURNS_MAX)) ?
                      htw_pkg::TURNS_MAX : TRN_W'(turns_full);
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        // push the timer at the head of its slot
        h_nxt    = head_out;
        tn_we    = 1'b1;
        sl_we    = 1'b1;
        pv_we    = 1'b1;
        pv_wdata = htw_pkg::NO_LINK;
        nx_we    = 1'b1;
        nx_wdata = head_out;
        hd_we    = 1'b1;
        hd_waddr = tslot_r;
        hd_wdata = {1'b0, id_r};
        act_set  = 1'b1;
        state_nxt = (head_out == htw_pkg::NO_LINK) ? S_IDLE : S_INS2;
      end
      S_INS2: begin
        pv_we     = 1'b1;
        pv_waddr  = h_r[ID_W-1:0];
        pv_wdata  = {1'b0, id_r};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory ports, registered reads
  always_ff @(posedge clk) begin
    if (hd_we) hd_mem[hd_waddr] <= hd_wdata;
    if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    if (tn_we) tn_mem[tn_waddr] <= tn_wdata;
    if (sl_we) sl_mem[sl_waddr] <= sl_wdata;
    hd_q <= hd_mem[hd_raddr];
    nx_q <= nx_mem[rc_raddr];
    pv_q <= pv_mem[rc_raddr];
    sl_q <= sl_mem[rc_raddr];
    tn_q <= tn_mem[rc_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= '0;
      hd_vld_r <= '0;
      act_r    <= '0;
      hd_vq    <= 1'b0;
      pend_r   <= 1'b0;
      ostb_r   <= 1'b0;
      ti_r     <= htw_pkg::DVS_W'(1);
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
      ostb_r  <= ostb_nxt;
      hd_vq   <= hd_vld_r[hd_raddr];
      if (hd_we) hd_vld_r[hd_waddr] <= 1'b1;
      if (act_set) begin
        act_r[act_addr] <= 1'b1;
      end else if (act_clr) begin
        act_r[act_addr] <= 1'b0;
      end
      if (cfg_we) ti_r <= cfg_data;
    end
    tslot_r <= tslot_nxt;
    id_r    <= id_nxt;
    t_r     <= t_nxt;
    kept_r  <= kept_nxt;
    h_r     <= h_nxt;
    ins_r   <= ins_nxt;
    pid_r   <= pid_nxt;
    turns_r <= turns_nxt;
    oid_r   <= oid_nxt;
    oexp_r  <= oexp_nxt;
    olast_r <= olast_nxt;
  end

endmodule
